@@ src/spq_pkg.sv @@
// Shared constants, types and helpers for the stable priority queue.
`default_nettype none
package spq_pkg;

    localparam int DEPTH    = 16;
    localparam int TAG_BITS = 16;
    localparam int OUT_TAG_BITS = 16;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_CALL = 1'b1;

    typedef enum logic [1:0] {
        ST_ADDED      = 2'd0,
        ST_DROP_FULL  = 2'd1,
        ST_CALLED     = 2'd2,
        ST_CALL_EMPTY = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ROOM_EMERGENCY    = 2'd0,
        ROOM_EXAMINATION  = 2'd1,
        ROOM_CONSULTATION = 2'd2
    } t_room;

    // Contents of one cell of the sorted chain.
    typedef struct packed {
        logic                valid;
        logic [1:0]          level;
        logic [TAG_BITS-1:0] tag;
    } t_slot;

    // Operation broadcast to every cell in a cycle.
    typedef struct packed {
        logic                add;
        logic                call;
        logic [1:0]          level;
        logic [TAG_BITS-1:0] tag;
    } t_cell_ctl;

    function automatic t_room room_of(input logic [1:0] lvl);
        t_room r;
        case (lvl)
            2'd0:    r = ROOM_EMERGENCY;
            2'd1:    r = ROOM_EXAMINATION;
            default: r = ROOM_CONSULTATION;
        endcase
        return r;
    endfunction

    function automatic logic [OUT_TAG_BITS-1:0] out_tag_of(input logic [TAG_BITS-1:0] t);
        logic [63:0] w;
        w = 64'(t);
        return w[OUT_TAG_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

@@ src/spq_cell.sv @@
// One cell of the sorted chain: holds one entry and trades it with its neighbors.
`default_nettype none
module spq_cell (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  spq_pkg::t_cell_ctl     i_ctl,
    input  spq_pkg::t_slot         i_left,
    input  spq_pkg::t_slot         i_right,
    output spq_pkg::t_slot         o_slot
);
    import spq_pkg::*;

    t_slot r_slot;
    t_slot n_slot;
    logic  w_left_keeps;
    logic  w_here_keeps;

    // An entry stays ahead of a new item when it is equally or more urgent.
    assign w_left_keeps = i_left.valid && (i_left.level <= i_ctl.level);
    assign w_here_keeps = r_slot.valid && (r_slot.level <= i_ctl.level);

    always_comb begin
        n_slot = r_slot;
        if (i_ctl.add) begin
            if (!w_left_keeps) begin
                n_slot = i_left;
            end else if (!w_here_keeps) begin
                n_slot.valid = 1'b1;
                n_slot.level = i_ctl.level;
                n_slot.tag   = i_ctl.tag;
            end
        end else if (i_ctl.call) begin
            n_slot = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
        end else begin
            r_slot.valid <= n_slot.valid;
        end
        r_slot.level <= n_slot.level;
        r_slot.tag   <= n_slot.tag;
    end

    assign o_slot = r_slot;

endmodule
`default_nettype wire

@@ src/stable_priority_queue_4level.sv @@
// Top level of the stable priority queue: a chain of sorted cells and an output register.
// The result of an item is registered and appears in the cycle after the item is accepted.
// Throughput: one item per cycle unless stalled; an add or call updates all cells at once.
// A held result blocks input only while the output side stalls.
// Reset (synchronous, active low) empties the queue and clears the output valid.
`default_nettype none
module stable_priority_queue_4level (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_valid,
    output logic                           o_stall,
    input  wire                            i_cmd,
    input  wire [spq_pkg::TAG_BITS-1:0]    i_tag,
    input  wire [1:0]                      i_level,
    output logic                           o_valid,
    input  wire                            i_stall,
    output logic [1:0]                     o_status,
    output logic [spq_pkg::OUT_TAG_BITS-1:0] o_out_tag,
    output logic [1:0]                     o_room
);
    import spq_pkg::*;

    t_slot     w_slot [DEPTH];
    t_slot     w_left [DEPTH];
    t_slot     w_right[DEPTH];
    t_cell_ctl w_ctl;
    logic      w_accept;
    logic      w_full;
    logic      w_empty;

    logic                    r_out_valid;
    t_status                 r_status;
    logic [OUT_TAG_BITS-1:0] r_out_tag;
    t_room                   r_room;

    t_status                 n_status;
    logic [OUT_TAG_BITS-1:0] n_out_tag;
    t_room                   n_room;

    assign o_stall  = r_out_valid && i_stall;
    assign w_accept = i_valid && !o_stall;
    assign w_full   = w_slot[DEPTH-1].valid;
    assign w_empty  = !w_slot[0].valid;

    always_comb begin
        w_ctl.add   = w_accept && (i_cmd == CMD_ADD) && !w_full;
        w_ctl.call  = w_accept && (i_cmd == CMD_CALL) && !w_empty;
        w_ctl.level = i_level;
        w_ctl.tag   = i_tag;
    end

    // The head cell sees a neighbor that always stays ahead; the tail sees an empty one.
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign w_left[g] = {1'b1, 2'd0, {TAG_BITS{1'b0}}};
            end else begin : g_mid
                assign w_left[g] = w_slot[g-1];
            end
            if (g == DEPTH - 1) begin : g_tail
                assign w_right[g] = {1'b0, 2'd0, {TAG_BITS{1'b0}}};
            end else begin : g_body
                assign w_right[g] = w_slot[g+1];
            end
            spq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_left  (w_left[g]),
                .i_right (w_right[g]),
                .o_slot  (w_slot[g])
            );
        end
    endgenerate

    always_comb begin
        n_status  = ST_ADDED;
        n_out_tag = '0;
        n_room    = ROOM_EMERGENCY;
        if (i_cmd == CMD_ADD) begin
            if (w_full) begin
                n_status = ST_DROP_FULL;
            end
        end else if (w_empty) begin
            n_status = ST_CALL_EMPTY;
        end else begin
            n_status  = ST_CALLED;
            n_out_tag = out_tag_of(w_slot[0].tag);
            n_room    = room_of(w_slot[0].level);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_accept) begin
            r_status  <= n_status;
            r_out_tag <= n_out_tag;
            r_room    <= n_room;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_status  = r_status;
    assign o_out_tag = r_out_tag;
    assign o_room    = r_room;

endmodule
`default_nettype wire
